FILE: rtl/core/fcfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfe_pkg
// Shared types and constants of the flash command front end.
// ----------------------------------------------------------------------------
package fcfe_pkg;

	localparam int LBA_W      = 64;
	localparam int LEN_W      = 32;
	localparam int PSZ_W      = 21;
	localparam int DIE_W      = 8;
	localparam int BLK_W      = 16;
	localparam int PG_W       = 16;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 21;

	localparam int LOGICAL_BLOCK_BYTES = 4096;
	localparam int LBLK_SHIFT          = $clog2(LOGICAL_BLOCK_BYTES);
	localparam int PPG_W               = PSZ_W - LBLK_SHIFT;

	localparam int QUO_W     = LBA_W;
	localparam int REM_W     = 32;
	localparam int DIV_STEPS = QUO_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_OTHER = 2'd2,
		OP_CMPL  = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_BAD_OPCODE  = 3'd1,
		ST_BAD_FIELD   = 3'd2,
		ST_CAPACITY    = 3'd3,
		ST_INTERNAL    = 3'd4,
		ST_WRITE_FAULT = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAGE_SIZE  = 2'd0,
		REG_DIE_COUNT  = 2'd1,
		REG_BLOCKS_DIE = 2'd2,
		REG_PAGES_BLK  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		status_t             status;
		logic                issue_nand;
		logic                nand_program;
		logic [DIE_W-1:0]    die_index;
		logic [BLK_W-1:0]    block_index;
		logic [PG_W-1:0]     page_in_block;
		logic [LEN_W-1:0]    transfer_bytes;
		logic                command_done;
	} result_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

FILE: rtl/core/fcfe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfe_if
// Request, response and register write channels of the flash command front end.
// ----------------------------------------------------------------------------
interface fcfe_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  opcode;
	logic [fcfe_pkg::LBA_W-1:0]  lba;
	logic                        data_present;
	logic [fcfe_pkg::LEN_W-1:0]  data_length;
	logic                        nand_response_ok;
	logic                        nand_status_ok;

	modport source (output valid, opcode, lba, data_present, data_length,
		nand_response_ok, nand_status_ok, input ready);
	modport sink (input valid, opcode, lba, data_present, data_length,
		nand_response_ok, nand_status_ok, output ready);
endinterface

interface fcfe_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [fcfe_pkg::STATUS_W-1:0]  status;
	logic                           issue_nand;
	logic                           nand_program;
	logic [fcfe_pkg::DIE_W-1:0]     die_index;
	logic [fcfe_pkg::BLK_W-1:0]     block_index;
	logic [fcfe_pkg::PG_W-1:0]      page_in_block;
	logic [fcfe_pkg::LEN_W-1:0]     transfer_bytes;
	logic                           command_done;

	modport source (output valid, status, issue_nand, nand_program, die_index,
		block_index, page_in_block, transfer_bytes, command_done, input ready);
	modport sink (input valid, status, issue_nand, nand_program, die_index,
		block_index, page_in_block, transfer_bytes, command_done, output ready);
endinterface

interface fcfe_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [fcfe_pkg::CFG_IDX_W-1:0]   index;
	logic [fcfe_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/fcfe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfe_div
// Shared restoring divider, one quotient bit per cycle, 64-bit dividend by a
// nonzero 32-bit divisor.
// ----------------------------------------------------------------------------
module fcfe_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fcfe_pkg::div_ctl_t          ctl,
	input  logic [fcfe_pkg::QUO_W-1:0]  dividend,
	input  logic [fcfe_pkg::REM_W-1:0]  divisor,
	output fcfe_pkg::div_sts_t          sts,
	output logic [fcfe_pkg::QUO_W-1:0]  quotient,
	output logic [fcfe_pkg::REM_W-1:0]  remainder
);
	import fcfe_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [QUO_W-1:0]     quo_q;
	logic [REM_W-1:0]     rem_q;
	logic [REM_W-1:0]     dvs_q;
	logic [REM_W:0]       trial;
	logic [REM_W:0]       diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[QUO_W-2:0], fits};
			rem_q <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/core/flash_command_front_end_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_command_front_end_unit
// Checks host read and write requests, maps the logical block address to a
// flash die, erase block and page, and turns NAND completions into status.
//
//   port  dir   handshake     carries
//   cmd   in    valid/ready   opcode, lba, data fields, completion flags
//   rsp   out   valid/ready   status, NAND target, transfer length, done
//   cfg   in    valid/ready   register index and write data, always ready
//
// a mapped read or write makes three passes through the shared 64-step divider
// (page, die, block), preceded by a multiply and followed by the finish state
// bad opcode, bad field and completions skip the divider, a die overrun the block pass
// cmd is ready only while the sequencer is idle, one request at a time
// a finished response waits in the output register; the next request is
// accepted meanwhile and only its last step waits for rsp to drain
// arst_n clears the sequencer, pending state and output valid, and config registers to their defaults
// ----------------------------------------------------------------------------
module flash_command_front_end_unit (
	input  logic        clk,
	input  logic        arst_n,
	fcfe_cmd_if.sink    cmd,
	fcfe_rsp_if.source  rsp,
	fcfe_cfg_if.sink    cfg
);
	import fcfe_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV_PAGE,
		S_DIV_DIE,
		S_DIV_BLK,
		S_FIN
	} state_t;

	state_t            state_q;
	logic [PSZ_W-1:0]  page_size_q;
	logic [DIE_W-1:0]  die_count_q;
	logic [BLK_W-1:0]  blocks_die_q;
	logic [PG_W-1:0]   pages_blk_q;

	logic              pend_q;
	logic              pend_wr_q;
	logic              cmpl_q;
	logic              wr_q;
	logic [LBA_W-1:0]  lba_q;
	logic [LEN_W-1:0]  len_q;
	logic [REM_W-1:0]  per_die_q;
	result_t           res_q;
	result_t           out_q;
	logic              out_valid_q;

	div_ctl_t          div_ctl_q;
	div_sts_t          div_sts;
	logic [QUO_W-1:0]  div_dividend_q;
	logic [REM_W-1:0]  div_divisor_q;
	logic [QUO_W-1:0]  div_quo;
	logic [REM_W-1:0]  div_rem;

	logic [PPG_W-1:0]  per_page;
	logic [BLK_W-1:0]  bpd_eff;
	logic [PG_W-1:0]   ppb_eff;
	logic              cmd_acc;
	logic              out_free;
	logic              cap_hit;
	logic              div_start;
	status_t           cmpl_status;
	result_t           res_base;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q  <= PSZ_W'(LOGICAL_BLOCK_BYTES);
			die_count_q  <= DIE_W'(1);
			blocks_die_q <= BLK_W'(1);
			pages_blk_q  <= PG_W'(1);
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_PAGE_SIZE:  page_size_q  <= cfg.data[PSZ_W-1:0];
				REG_DIE_COUNT:  die_count_q  <= cfg.data[DIE_W-1:0];
				REG_BLOCKS_DIE: blocks_die_q <= cfg.data[BLK_W-1:0];
				REG_PAGES_BLK:  pages_blk_q  <= cfg.data[PG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// effective divisors, zero counts as one
	always_comb begin
		per_page = page_size_q[PSZ_W-1:LBLK_SHIFT];
		if (per_page == '0) per_page = PPG_W'(1);
		bpd_eff = (blocks_die_q == '0) ? BLK_W'(1) : blocks_die_q;
		ppb_eff = (pages_blk_q == '0) ? PG_W'(1) : pages_blk_q;
	end

	always_comb begin
		if (!pend_q) begin
			cmpl_status = ST_INTERNAL;
		end else if (pend_wr_q) begin
			cmpl_status = !cmd.nand_status_ok ? ST_WRITE_FAULT :
				(!cmd.nand_response_ok ? ST_INTERNAL : ST_OK);
		end else begin
			cmpl_status = (!cmd.nand_status_ok || !cmd.nand_response_ok) ?
				ST_INTERNAL : ST_OK;
		end
	end

	// early status (completion, bad opcode or bad field), replaced later on the mapping path
	always_comb begin
		res_base              = '0;
		res_base.command_done = 1'b1;
		case (opcode_t'(cmd.opcode))
			OP_CMPL:  res_base.status = cmpl_status;
			OP_OTHER: res_base.status = ST_BAD_OPCODE;
			default:  res_base.status = ST_BAD_FIELD;
		endcase
	end

	assign cmd_acc  = cmd.valid && cmd.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign cap_hit  = div_quo >= QUO_W'(die_count_q);
	assign div_start = (state_q == S_MUL) ||
		(div_sts.done && (state_q == S_DIV_PAGE || (state_q == S_DIV_DIE && !cap_hit)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			pend_wr_q   <= 1'b0;
			cmpl_q      <= 1'b0;
			out_valid_q <= 1'b0;
			div_ctl_q   <= '0;
		end else begin
			div_ctl_q.start <= div_start;
			if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
			else if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						lba_q  <= cmd.lba;
						len_q  <= cmd.data_length;
						wr_q   <= (opcode_t'(cmd.opcode) == OP_WRITE);
						cmpl_q <= (opcode_t'(cmd.opcode) == OP_CMPL);
						res_q  <= res_base;
						case (opcode_t'(cmd.opcode))
							OP_CMPL:  state_q <= S_FIN;
							OP_OTHER: state_q <= S_FIN;
							default: begin
								if (!cmd.data_present || cmd.data_length == '0) begin
									state_q <= S_FIN;
								end else begin
									state_q <= S_MUL;
								end
							end
						endcase
					end
				end
				S_MUL: begin
					per_die_q       <= REM_W'(bpd_eff) * REM_W'(ppb_eff);
					div_dividend_q  <= lba_q;
					div_divisor_q   <= REM_W'(per_page);
					state_q         <= S_DIV_PAGE;
				end
				S_DIV_PAGE: begin
					if (div_sts.done) begin
						div_dividend_q  <= div_quo;
						div_divisor_q   <= per_die_q;
						state_q         <= S_DIV_DIE;
					end
				end
				S_DIV_DIE: begin
					if (div_sts.done) begin
						if (cap_hit) begin
							res_q.status <= ST_CAPACITY;
							state_q      <= S_FIN;
						end else begin
							res_q.die_index <= div_quo[DIE_W-1:0];
							div_dividend_q  <= QUO_W'(div_rem);
							div_divisor_q   <= REM_W'(ppb_eff);
							state_q         <= S_DIV_BLK;
						end
					end
				end
				S_DIV_BLK: begin
					if (div_sts.done) begin
						res_q.status         <= ST_OK;
						res_q.issue_nand     <= 1'b1;
						res_q.nand_program   <= wr_q;
						res_q.block_index    <= div_quo[BLK_W-1:0];
						res_q.page_in_block  <= div_rem[PG_W-1:0];
						res_q.transfer_bytes <= len_q;
						res_q.command_done   <= 1'b0;
						state_q              <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_q <= res_q;
						if (cmpl_q) begin
							pend_q    <= 1'b0;
							pend_wr_q <= 1'b0;
						end else if (res_q.issue_nand) begin
							pend_q    <= 1'b1;
							pend_wr_q <= res_q.nand_program;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	fcfe_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl_q),
		.dividend  (div_dividend_q),
		.divisor   (div_divisor_q),
		.sts       (div_sts),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign cmd.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.issue_nand    = out_q.issue_nand;
	assign rsp.nand_program  = out_q.nand_program;
	assign rsp.die_index     = out_q.die_index;
	assign rsp.block_index   = out_q.block_index;
	assign rsp.page_in_block = out_q.page_in_block;
	assign rsp.transfer_bytes = out_q.transfer_bytes;
	assign rsp.command_done  = out_q.command_done;

	// divider only runs while the sequencer waits on it
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		(div_sts.busy || div_sts.done) |->
		(state_q == S_DIV_PAGE || state_q == S_DIV_DIE || state_q == S_DIV_BLK))
		else $error("divider active outside a divide state");

	// an issued command shown on rsp is recorded as pending
	a_issue_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.issue_nand) |-> pend_q)
		else $error("issued command not pending");

	// an issued command is never final and always successful
	a_issue_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.issue_nand) |->
		(rsp.status == ST_OK && !rsp.command_done))
		else $error("issued command with bad status");

	// a finished request holds while the output register is blocked
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && !rsp.ready) |=> (state_q == S_FIN))
		else $error("response overwritten while blocked");

endmodule
